### sv/lee_pkg.sv
package lee_pkg;

    localparam int ChannelCount = 16;
    localparam int ChW = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;

    localparam logic [1:0] ActTick = 2'd0;
    localparam logic [1:0] ActSetOne = 2'd1;
    localparam logic [1:0] ActSetAll = 2'd2;

    localparam logic [2:0] EffOff = 3'd0;
    localparam logic [2:0] EffSolid = 3'd1;
    localparam logic [2:0] EffBlink = 3'd2;
    localparam logic [2:0] EffFade = 3'd3;
    localparam logic [2:0] EffStrobe = 3'd4;

    localparam logic RegTickStep = 1'b0;
    localparam logic RegStrobeCap = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic          load;      // capture input transaction
        logic          prog;      // program channel r_idx
        logic          tick_rd;   // read channel for tick, start divide
        logic          tick_div;  // divider step
        logic          tick_wr;   // write back tick result
        logic          emit_ld;   // load output register from channel r_idx
        logic [ChW-1:0] idx;
        logic          last;
    } t_cmd;

    // Datapath status
    typedef struct packed {
        logic div_done;
        logic changed;
        logic anim;
    } t_sts;

    function automatic logic is_anim(input logic [2:0] m);
        return (m != EffOff) && (m != EffSolid);
    endfunction

endpackage

### sv/led_effect_engine.sv
// channel  direction  handshake            payload
// in       input      i_valid / o_ready    action, channel, effect, colors, period
// out      output     o_valid / i_ready    pixel_index, rgb, frame_end, animating
// cfg      input      i_cfg_we             i_cfg_idx, i_cfg_data
// A tick walks all channels in turn: a 17-step restoring modulo divider plus read, finish,
// done handoff and write-back for each channel, and three more lane divides for a fade channel.
// A set programs the selected channel, or every channel in turn, after the accept cycle.
// A frame sends one pixel at a time, loaded into the output register and held until the receiver is ready.
// Reset is synchronous active low and clears all channel state at once.
// Output stalls hold the sequencer; no new transaction is taken until done.
module led_effect_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_channel,
    input  logic [2:0]  i_effect,
    input  logic [23:0] i_first_color,
    input  logic [23:0] i_second_color,
    input  logic [15:0] i_period_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_frame_end,
    output logic        o_animating,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);

    lee_pkg::t_cmd cmd;
    lee_pkg::t_sts sts;
    logic [23:0] color;

    lee_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action, .i_channel, .i_effect,
        .o_valid, .i_ready, .o_cmd(cmd), .i_sts(sts), .o_anim(o_animating)
    );

    lee_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_effect, .i_first_color, .i_second_color, .i_period_ms,
        .o_pixel_index, .o_color(color), .o_frame_end
    );

    assign o_red   = color[23:16];
    assign o_green = color[15:8];
    assign o_blue  = color[7:0];

endmodule

### sv/lee_datapath.sv
module lee_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lee_pkg::t_cmd               i_cmd,
    output lee_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [9:0]                  i_cfg_data,
    input  logic [2:0]                  i_effect,
    input  logic [23:0]                 i_first_color,
    input  logic [23:0]                 i_second_color,
    input  logic [15:0]                 i_period_ms,
    output logic [5:0]                  o_pixel_index,
    output logic [23:0]                 o_color,
    output logic                        o_frame_end
);

    logic [9:0]  r_step, r_cap;
    logic [2:0]  r_mode  [lee_pkg::ChannelCount];
    logic [23:0] r_pri   [lee_pkg::ChannelCount];
    logic [23:0] r_sec   [lee_pkg::ChannelCount];
    logic [15:0] r_per   [lee_pkg::ChannelCount];
    logic [16:0] r_ela   [lee_pkg::ChannelCount];
    logic [23:0] r_shown [lee_pkg::ChannelCount];

    logic [2:0]  r_in_eff;
    logic [23:0] r_in_c1, r_in_c2;
    logic [15:0] r_in_per;

    // Tick working registers
    logic [15:0] r_p;
    logic [16:0] r_e;
    logic [4:0]  r_cnt;
    logic [1:0]  r_ph;       // 0 modulo, 1..3 lerp channels
    logic        r_lane_ld;  // load the dividend of lane r_ph next
    logic [16:0] r_rem;      // restoring-division remainder
    logic [23:0] r_quo;      // dividend bits shifted out / quotient
    logic        r_neg;
    logic [7:0]  r_res [3];
    logic        r_changed;
    logic        r_done;

    logic [16:0] e_sum;
    logic [14:0] half;
    logic        fwd;
    logic [15:0] fstep;
    logic [7:0]  ca, cb;
    logic [8:0]  dmag;
    logic [23:0] prod;
    logic [17:0] trial;
    logic [23:0] col;
    logic [15:0] on_t;
    logic        anim_any;

    assign half  = r_p[15:1];
    assign fwd   = (r_e <= {2'b0, half});
    assign fstep = fwd ? r_e[15:0] : (r_e[15:0] - {1'b0, half});

    // Byte select for the fade lane
    always_comb begin
        logic [23:0] a, b;
        a = fwd ? r_pri[i_cmd.idx] : r_sec[i_cmd.idx];
        b = fwd ? r_sec[i_cmd.idx] : r_pri[i_cmd.idx];
        case (r_ph)
            2'd1:    begin ca = a[23:16]; cb = b[23:16]; end
            2'd2:    begin ca = a[15:8];  cb = b[15:8];  end
            default: begin ca = a[7:0];   cb = b[7:0];   end
        endcase
        dmag = (cb >= ca) ? {1'b0, cb - ca} : {1'b0, ca - cb};
        prod = 24'(dmag) * 24'(fstep);
    end

    assign trial = {r_rem, r_quo[23]} - ((r_ph == 2'd0) ? {2'b0, r_p} : {3'b0, half});

    // Tick color selection after modulo and lerp finish
    always_comb begin
        on_t = ({6'b0, r_cap} < r_p) ? {6'b0, r_cap} : {2'b0, r_p[15:2]};
        col  = r_shown[i_cmd.idx];
        case (r_mode[i_cmd.idx])
            lee_pkg::EffBlink:
                col = (r_e < {2'b0, half}) ? r_pri[i_cmd.idx] : r_sec[i_cmd.idx];
            lee_pkg::EffFade:
                if (half != '0) col = {r_res[0], r_res[1], r_res[2]};
            lee_pkg::EffStrobe:
                col = (r_e < {1'b0, on_t}) ? r_pri[i_cmd.idx] : 24'd0;
            default: ;
        endcase
    end

    assign e_sum = r_ela[i_cmd.idx] + {7'b0, r_step};

    always_comb begin
        anim_any = 1'b0;
        for (int k = 0; k < lee_pkg::ChannelCount; k++)
            anim_any = anim_any | lee_pkg::is_anim(r_mode[k]);
    end

    assign o_sts = '{div_done: r_done, changed: r_changed, anim: anim_any};

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 10'd20;
            r_cap  <= 10'd50;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lee_pkg::RegTickStep) r_step <= i_cfg_data;
            else r_cap <= i_cfg_data;
        end
    end

    // Input capture (payload only)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_eff <= i_effect;
            r_in_c1  <= i_first_color;
            r_in_c2  <= i_second_color;
            r_in_per <= (i_period_ms == '0) ? 16'd1 : i_period_ms;
        end
    end

    // Channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lee_pkg::ChannelCount; k++) begin
                r_mode[k] <= lee_pkg::EffOff;
                r_pri[k] <= '0; r_sec[k] <= '0; r_per[k] <= 16'd1000;
                r_ela[k] <= '0; r_shown[k] <= '0;
            end
        end else if (i_cmd.prog) begin
            r_mode[i_cmd.idx] <= r_in_eff;
            r_pri[i_cmd.idx]  <= r_in_c1;
            r_sec[i_cmd.idx]  <= r_in_c2;
            r_per[i_cmd.idx]  <= r_in_per;
            r_ela[i_cmd.idx]  <= '0;
            if (r_in_eff == lee_pkg::EffOff) r_shown[i_cmd.idx] <= '0;
            else if (r_in_eff == lee_pkg::EffSolid) r_shown[i_cmd.idx] <= r_in_c1;
        end else if (i_cmd.tick_wr) begin
            r_ela[i_cmd.idx]   <= r_e;
            r_shown[i_cmd.idx] <= col;
        end
    end

    // Iterative divider: modulo by period, then for a fade channel one lerp quotient per color lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_changed <= 1'b0;
            r_lane_ld <= 1'b0;
        end else begin
            if (i_cmd.load) r_changed <= 1'b0;
            else if (i_cmd.tick_wr && (col != r_shown[i_cmd.idx])) r_changed <= 1'b1;
            if (i_cmd.tick_rd) begin
                r_p   <= (r_per[i_cmd.idx] == '0) ? 16'd1 : r_per[i_cmd.idx];
                r_e   <= e_sum;
                r_ph  <= 2'd0;
                r_rem <= '0;
                r_quo <= {e_sum, 7'b0};
                r_cnt <= 5'd17;
                r_lane_ld <= 1'b0;
                r_done <= 1'b0;
            end else if (i_cmd.tick_div && !r_done) begin
                if (r_cnt != '0) begin
                    if (!trial[17]) begin
                        r_rem <= trial[16:0];
                        r_quo <= {r_quo[22:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[15:0], r_quo[23]};
                        r_quo <= {r_quo[22:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 5'd1;
                end else if (r_lane_ld) begin
                    // dividend |d| * step for lane r_ph, with wrapped elapsed in place
                    r_quo     <= prod;
                    r_neg     <= (cb < ca);
                    r_rem     <= '0;
                    r_cnt     <= 5'd24;
                    r_lane_ld <= 1'b0;
                end else if (r_ph == 2'd0) begin
                    if (r_e >= {1'b0, r_p}) r_e <= r_rem;
                    if ((r_mode[i_cmd.idx] == lee_pkg::EffFade) && (half != '0)) begin
                        r_ph      <= 2'd1;
                        r_lane_ld <= 1'b1;
                    end else begin
                        r_done <= 1'b1;
                    end
                end else begin
                    // quotient ready for lane r_ph-1; start next lane
                    r_res[r_ph - 2'd1] <= r_neg ? 8'(ca - r_quo[7:0]) : 8'(ca + r_quo[7:0]);
                    if (r_ph == 2'd3) r_done <= 1'b1;
                    else begin
                        r_ph      <= r_ph + 2'd1;
                        r_lane_ld <= 1'b1;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            o_pixel_index <= 6'(i_cmd.idx);
            o_color       <= r_shown[i_cmd.idx];
            o_frame_end   <= i_cmd.last;
        end
    end

endmodule

### sv/lee_ctrl.sv
module lee_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_action,
    input  logic [5:0]     i_channel,
    input  logic [2:0]     i_effect,
    output logic           o_valid,
    input  logic           i_ready,
    output lee_pkg::t_cmd  o_cmd,
    input  lee_pkg::t_sts  i_sts,
    output logic           o_anim
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PROG = 7'b0000010,
        S_TRD  = 7'b0000100,
        S_TDIV = 7'b0001000,
        S_TWR  = 7'b0010000,
        S_ELD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [lee_pkg::ChW-1:0] r_idx, n_idx;
    logic r_all, n_all, r_emit, n_emit, r_ov, n_ov, r_anim, n_anim;
    logic acc, lastc;

    assign o_ready = (r_st == S_IDLE);
    assign acc     = i_valid && o_ready;
    assign lastc   = (32'(r_idx) == lee_pkg::ChannelCount - 1);
    assign o_valid = r_ov;
    assign o_anim  = r_anim;

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_all = r_all; n_emit = r_emit;
        n_ov = r_ov; n_anim = r_anim;
        o_cmd = '0;
        o_cmd.idx  = r_idx;
        o_cmd.last = lastc;
        case (r_st)
            S_IDLE: if (acc) begin
                o_cmd.load = 1'b1;
                n_emit = !lee_pkg::is_anim(i_effect);
                case (i_action)
                    lee_pkg::ActTick: begin
                        // a tick emits only when a color changed
                        n_emit = 1'b0; n_idx = '0; n_st = S_TRD;
                    end
                    lee_pkg::ActSetOne:
                        if (32'(i_channel) < lee_pkg::ChannelCount) begin
                            n_idx = i_channel[lee_pkg::ChW-1:0]; n_all = 1'b0; n_st = S_PROG;
                        end
                    lee_pkg::ActSetAll: begin n_idx = '0; n_all = 1'b1; n_st = S_PROG; end
                    default: ;
                endcase
            end
            S_PROG: begin
                o_cmd.prog = 1'b1;
                if (r_all && !lastc) n_idx = r_idx + 1'b1;
                else if (r_emit) begin n_idx = '0; n_st = S_ELD; end
                else n_st = S_IDLE;
            end
            S_TRD: begin
                o_cmd.tick_rd = 1'b1;
                n_st = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.tick_div = 1'b1;
                if (i_sts.div_done) n_st = S_TWR;
            end
            S_TWR: begin
                o_cmd.tick_wr = 1'b1;
                if (!lastc) begin n_idx = r_idx + 1'b1; n_st = S_TRD; end
                else begin n_idx = '0; n_st = S_ELD; end
            end
            S_ELD: begin
                // skipped tick when nothing changed
                if (!r_emit && !i_sts.changed) n_st = S_IDLE;
                else begin
                    o_cmd.emit_ld = 1'b1;
                    n_anim = i_sts.anim;
                    n_ov = 1'b1;
                    n_st = S_OUT;
                end
            end
            S_OUT: if (i_ready) begin
                n_ov = 1'b0;
                if (lastc) n_st = S_IDLE;
                else begin n_idx = r_idx + 1'b1; n_st = S_ELD; n_emit = 1'b1; end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_idx <= '0; r_all <= 1'b0; r_emit <= 1'b0;
            r_ov <= 1'b0; r_anim <= 1'b0;
        end else begin
            r_st <= n_st; r_idx <= n_idx; r_all <= n_all; r_emit <= n_emit;
            r_ov <= n_ov; r_anim <= n_anim;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while output pending");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not onehot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("output dropped");

endmodule

### verif/lee_checker.sv
module lee_checker
    import lee_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_channel,
    input  logic [2:0]  i_effect,
    input  logic [23:0] i_first_color,
    input  logic [23:0] i_second_color,
    input  logic [15:0] i_period_ms,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [5:0]  o_pixel_index,
    input  logic [7:0]  o_red,
    input  logic [7:0]  o_green,
    input  logic [7:0]  o_blue,
    input  logic        o_frame_end,
    input  logic        o_animating,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_frames
);

    typedef struct packed {
        logic [5:0] pix;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
        logic       anim;
    } t_pixel;

    t_pixel pixel_q[$];

    logic [9:0]  step_ms;
    logic [9:0]  strobe_cap;
    logic [2:0]  mode_r[ChannelCount];
    logic [23:0] col_a[ChannelCount];
    logic [23:0] col_b[ChannelCount];
    logic [15:0] per_r[ChannelCount];
    logic [16:0] elap_r[ChannelCount];
    logic [23:0] shown_r[ChannelCount];

    // linear blend of one byte, truncating toward zero
    function automatic logic [7:0] blend8(input int a, input int b, input int st, input int sp);
        int v;
        v = a + ((b - a) * st) / sp;
        return v[7:0];
    endfunction

    function automatic logic [23:0] blend_rgb(input logic [23:0] a, input logic [23:0] b,
                                               input int st, input int sp);
        return {blend8(a[23:16], b[23:16], st, sp), blend8(a[15:8], b[15:8], st, sp),
                blend8(a[7:0], b[7:0], st, sp)};
    endfunction

    task automatic queue_frame();
        t_pixel p;
        logic an;
        an = 1'b0;
        for (int i = 0; i < ChannelCount; i++) if (is_anim(mode_r[i])) an = 1'b1;
        for (int i = 0; i < ChannelCount; i++) begin
            p.pix = 6'(i);
            {p.r, p.g, p.b} = shown_r[i];
            p.last = (i == ChannelCount - 1);
            p.anim = an;
            pixel_q.push_back(p);
        end
    endtask

    task automatic program_ch(input int i);
        mode_r[i] = i_effect;
        col_a[i] = i_first_color;
        col_b[i] = i_second_color;
        per_r[i] = (i_period_ms == 0) ? 16'd1 : i_period_ms;
        elap_r[i] = '0;
        if (i_effect == EffOff) shown_r[i] = '0;
        else if (i_effect == EffSolid) shown_r[i] = i_first_color;
    endtask

    task automatic advance_effects();
        bit changed;
        int p, half, e, on;
        logic [23:0] c;
        changed = 0;
        for (int i = 0; i < ChannelCount; i++) begin
            if (!is_anim(mode_r[i])) continue;
            p = per_r[i];
            half = p / 2;
            e = elap_r[i] + step_ms;
            if (e >= p) e = e % p;
            elap_r[i] = 17'(e);
            c = shown_r[i];
            case (mode_r[i])
                EffBlink: c = (e < half) ? col_a[i] : col_b[i];
                EffFade: begin
                    if (half != 0) begin
                        if (e <= half) c = blend_rgb(col_a[i], col_b[i], e, half);
                        else c = blend_rgb(col_b[i], col_a[i], e - half, half);
                    end
                end
                EffStrobe: begin
                    on = (p > strobe_cap) ? int'(strobe_cap) : p / 4;
                    c = (e < on) ? col_a[i] : 24'd0;
                end
                default: ;
            endcase
            if (c != shown_r[i]) begin
                shown_r[i] = c;
                changed = 1;
            end
        end
        if (changed) queue_frame();
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_pixel w;
        if (!i_rst_n) begin
            step_ms = 10'd20;
            strobe_cap = 10'd50;
            o_errors = 0;
            o_frames = 0;
            pixel_q.delete();
            for (int i = 0; i < ChannelCount; i++) begin
                mode_r[i] = EffOff;
                col_a[i] = '0;
                col_b[i] = '0;
                per_r[i] = 16'd1000;
                elap_r[i] = '0;
                shown_r[i] = '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegTickStep) step_ms = i_cfg_data;
                else strobe_cap = i_cfg_data;
            end
            // input transaction
            if (i_valid && o_ready) begin
                case (i_action)
                    ActTick: advance_effects();
                    ActSetOne: begin
                        if (i_channel < ChannelCount) begin
                            program_ch(i_channel);
                            if (!is_anim(i_effect)) queue_frame();
                        end
                    end
                    ActSetAll: begin
                        for (int i = 0; i < ChannelCount; i++) program_ch(i);
                        if (!is_anim(i_effect)) queue_frame();
                    end
                    default: ;
                endcase
            end
            // output transaction
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected pixel", o_pixel_index, -1);
                end else begin
                    w = pixel_q.pop_front();
                    if (o_pixel_index != w.pix) report("pixel_index", o_pixel_index, w.pix);
                    if (o_red != w.r) report("red", o_red, w.r);
                    if (o_green != w.g) report("green", o_green, w.g);
                    if (o_blue != w.b) report("blue", o_blue, w.b);
                    if (o_frame_end != w.last) report("frame_end", o_frame_end, w.last);
                    if (o_animating != w.anim) report("animating", o_animating, w.anim);
                    if (w.last) o_frames++;
                end
            end
        end
        o_pending = pixel_q.size();
    end

endmodule

### verif/tb.sv
module tb;
    import lee_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [5:0]  i_channel;
    logic [2:0]  i_effect;
    logic [23:0] i_first_color;
    logic [23:0] i_second_color;
    logic [15:0] i_period_ms;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_pixel_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_frame_end;
    logic        o_animating;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [9:0]  i_cfg_data;

    int errors, pending, frames;
    int send_idle, recv_idle;
    bit hold_off;
    int idle_cycles;
    int sent;

    led_effect_engine u_top (.*);

    lee_checker u_chk (
        .*, .o_errors(errors), .o_pending(pending), .o_frames(frames)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_action = ActTick;
        i_channel = '0;
        i_effect = EffOff;
        i_first_color = '0;
        i_second_color = '0;
        i_period_ms = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = RegTickStep;
        i_cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_off = 0;
    end

    // receiver: random stalls, plus long hold-off when asked
    always @(posedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 40000) begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // valid stays up after a transaction until the next idle gap or drain
    task automatic send(input logic [1:0] act, input logic [5:0] ch, input logic [2:0] eff,
                        input logic [23:0] c1, input logic [23:0] c2, input logic [15:0] per);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_channel <= ch;
        i_effect <= eff;
        i_first_color <= c1;
        i_second_color <= c2;
        i_period_ms <= per;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic tick();
        send(ActTick, '0, EffOff, '0, '0, '0);
    endtask

    // mostly well-formed: a random mix of ticks and channel programs
    task automatic random_item();
        int k;
        logic [15:0] per;
        k = $urandom_range(99);
        per = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
        if (k < 55) tick();
        else if (k < 80) send(ActSetOne, 6'($urandom_range(ChannelCount - 1)),
                             3'($urandom_range(2, 4)), 24'($urandom), 24'($urandom), per);
        else if (k < 88) send(ActSetOne, 6'($urandom), 3'($urandom), 24'($urandom),
                             24'($urandom), per);
        else if (k < 95) send(ActSetAll, 6'($urandom), 3'($urandom), 24'($urandom),
                             24'($urandom), per);
        else send(2'd3, 6'($urandom), 3'($urandom), 24'($urandom), 24'($urandom), per);
    endtask

    initial begin
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every action and effect, field extremes
        send(ActSetAll, 6'd0, EffSolid, 24'hFFFFFF, 24'h0, 16'd0);
        send(ActSetOne, 6'd63, EffSolid, 24'h123456, 24'h0, 16'd5);
        send(ActSetOne, 6'd15, EffOff, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send(2'd3, 6'd0, EffSolid, 24'h0, 24'h0, 16'd0);
        tick();
        send(ActSetOne, 6'd0, EffBlink, 24'hFF0000, 24'h00FF00, 16'd100);
        send(ActSetOne, 6'd1, EffFade, 24'h000000, 24'hFFFFFF, 16'd200);
        send(ActSetOne, 6'd2, EffFade, 24'hFF80FF, 24'h00FF01, 16'd1);
        send(ActSetOne, 6'd3, EffStrobe, 24'hABCDEF, 24'h0, 16'd30);
        send(ActSetOne, 6'd4, EffStrobe, 24'h808080, 24'h0, 16'd0);
        send(ActSetOne, 6'd5, 3'd5, 24'h010101, 24'h0, 16'd70);
        send(ActSetOne, 6'd6, 3'd7, 24'h0, 24'h0, 16'hFFFF);
        send(ActSetOne, 6'd7, 3'd6, 24'h0, 24'h0, 16'd3);
        repeat (8) tick();
        send(ActSetAll, 6'd0, EffStrobe, 24'hFFFFFF, 24'hFFFFFF, 16'd400);
        repeat (3) tick();
        drain();

        write_reg(RegTickStep, 10'd0);
        write_reg(RegStrobeCap, 10'd0);
        send(ActSetAll, 6'd0, EffBlink, 24'h00FF00, 24'hFF00FF, 16'd40);
        repeat (3) tick();
        drain();
        write_reg(RegTickStep, 10'd1023);
        write_reg(RegStrobeCap, 10'd1023);
        repeat (4) tick();
        drain();

        // random phases with different idle mixes and settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 35 : (ph == 1) ? 69 : 0;
            recv_idle = (ph == 0) ? 69 : (ph == 1) ? 35 : 0;
            write_reg(RegTickStep, 10'($urandom_range(1, 120)));
            write_reg(RegStrobeCap, 10'($urandom_range(1023)));
            for (int n = 0; n < 95; n++) random_item();
            drain();
        end

        // receiver holds off while the sender keeps offering
        send(ActSetAll, 6'd0, EffSolid, 24'h0F0F0F, 24'h0, 16'd9);
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                send(ActSetOne, 6'd9, EffSolid, 24'hF0F0F0, 24'h0, 16'd9);
                send(ActSetOne, 6'd8, EffOff, 24'h0, 24'h0, 16'd9);
            end
        join
        drain();

        $display("covered %0d input transactions and %0d frames", sent, frames);
        $display("all effects, actions, channel range edges and register extremes driven");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### led_effect_engine.f
sv/lee_pkg.sv
sv/lee_datapath.sv
sv/lee_ctrl.sv
sv/led_effect_engine.sv
verif/lee_checker.sv
verif/tb.sv
